/* design/udp_command_header_parser_core_defines.svh */
// Assertion macros shared by the datagram header parser modules.
// Expect clk_i and rst_ni in the scope where they are used.
`ifndef UDP_COMMAND_HEADER_PARSER_CORE_DEFINES_SVH
`define UDP_COMMAND_HEADER_PARSER_CORE_DEFINES_SVH

// same-cycle implication
`define UCP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ucp assertion failed");

// next-cycle implication
`define UCP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ucp assertion failed");

`endif

/* design/ucp_pkg.sv */
// Types and constants for the datagram command header parser.
// No dependencies; used by all design modules.
package ucp_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned HALF_W    = 16;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned USED_W    = 4;
  localparam int unsigned CFG_IDX_W = 2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_MAGIC = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_LEN   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXLEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INT16  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INT32  = 2'd3;

  // byte counts at which a field completes
  localparam logic [POS_W-1:0] POS_MAGIC = 5'd4;
  localparam logic [POS_W-1:0] POS_LEN   = 5'd8;
  localparam logic [POS_W-1:0] POS_MSG   = 5'd10;
  localparam logic [POS_W-1:0] POS_CMD   = 5'd12;
  localparam logic [POS_W-1:0] POS_VTYPE = 5'd14;
  localparam logic [POS_W-1:0] POS_VAL16 = 5'd16;
  localparam logic [POS_W-1:0] POS_VAL32 = 5'd18;

  // bytes consumed after the magic word
  localparam logic [USED_W-1:0] USED_NONE  = 4'd10;
  localparam logic [USED_W-1:0] USED_VAL16 = 4'd12;
  localparam logic [USED_W-1:0] USED_VAL32 = 4'd14;

  // configuration reset values
  localparam logic [WORD_W-1:0] RST_MAGIC  = 32'h0000_0000;
  localparam logic [WORD_W-1:0] RST_MAXLEN = 32'h0000_FFFF;
  localparam logic [HALF_W-1:0] RST_INT16  = 16'd1;
  localparam logic [HALF_W-1:0] RST_INT32  = 16'd2;

  typedef struct packed {
    logic [WORD_W-1:0] magic_word;
    logic [WORD_W-1:0] len_limit;
    logic [HALF_W-1:0] int16_type_code;
    logic [HALF_W-1:0] int32_type_code;
  } cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [HALF_W-1:0]        msg_kind;
    logic [HALF_W-1:0]        command_code;
    logic [HALF_W-1:0]        val_kind;
    logic signed [WORD_W-1:0] payload_value;
    logic [USED_W-1:0]        bytes_used;
  } res_t;

endpackage

/* design/ucp_parse.sv */
// Input register and header field assembly for the datagram parser.
// Depends on ucp_pkg and the shared assertion macro header.
`include "udp_command_header_parser_core_defines.svh"

module ucp_parse (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ucp_pkg::cfg_t                 cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ucp_pkg::BYTE_W-1:0]    data_byte_i,
  input  logic                          first_byte_i,
  input  logic                          buf_full_i,
  output logic                          res_push_o,
  output ucp_pkg::res_t                 res_o
);
  import ucp_pkg::*;

  logic              in_valid_q, in_valid_d;
  logic [BYTE_W-1:0] data_q;
  logic              first_q;
  logic              accept, take;

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [WORD_W-1:0] shift_q, shift_d;
  logic [HALF_W-1:0] hw0_q, hw0_d, hw1_q, hw1_d, hw2_q, hw2_d;
  logic              bad_q, bad_d;
  logic              fin_q, fin_d;

  logic              live;
  logic              emit;
  logic [STATUS_W-1:0] emit_st;
  logic [WORD_W-1:0] emit_val;
  logic [USED_W-1:0] emit_used;
  logic [POS_W-1:0]  pos_n;
  logic [WORD_W-1:0] shift_n;
  logic              ok;

  assign in_stall_o = in_valid_q & buf_full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign take       = in_valid_q & ~buf_full_i;
  assign in_valid_d = accept | (in_valid_q & ~take);

  // a byte outside an open datagram is dropped without a result
  assign live    = take & (first_q | ~fin_q);
  assign pos_n   = first_q ? POS_W'(1) : pos_q + POS_W'(1);
  assign shift_n = first_q ? {{(WORD_W-BYTE_W){1'b0}}, data_q}
                           : {shift_q[WORD_W-BYTE_W-1:0], data_q};

  always_comb begin
    pos_d     = pos_q;
    shift_d   = shift_q;
    hw0_d     = hw0_q;
    hw1_d     = hw1_q;
    hw2_d     = hw2_q;
    bad_d     = bad_q;
    fin_d     = fin_q;
    emit      = 1'b0;
    emit_st   = ST_OK;
    emit_val  = '0;
    emit_used = '0;
    if (live) begin
      pos_d   = pos_n;
      shift_d = shift_n;
      if (first_q) begin
        hw0_d = '0;
        hw1_d = '0;
        hw2_d = '0;
        bad_d = 1'b0;
        fin_d = 1'b0;
      end
      case (pos_n)
        POS_MAGIC: bad_d = (shift_n != cfg_i.magic_word);
        POS_LEN: begin
          if (bad_d) begin
            emit    = 1'b1;
            emit_st = ST_BAD_MAGIC;
          end else if (shift_n > cfg_i.len_limit) begin
            emit    = 1'b1;
            emit_st = ST_BAD_LEN;
          end
        end
        POS_MSG: hw0_d = shift_n[HALF_W-1:0];
        POS_CMD: hw1_d = shift_n[HALF_W-1:0];
        POS_VTYPE: begin
          hw2_d = shift_n[HALF_W-1:0];
          if (shift_n[HALF_W-1:0] != cfg_i.int16_type_code &&
              shift_n[HALF_W-1:0] != cfg_i.int32_type_code) begin
            emit      = 1'b1;
            emit_used = USED_NONE;
          end
        end
        POS_VAL16: begin
          if (hw2_q == cfg_i.int16_type_code) begin
            emit      = 1'b1;
            emit_val  = {{HALF_W{shift_n[HALF_W-1]}}, shift_n[HALF_W-1:0]};
            emit_used = USED_VAL16;
          end
        end
        POS_VAL32: begin
          emit      = 1'b1;
          emit_val  = shift_n;
          emit_used = USED_VAL32;
        end
        default: ;
      endcase
      if (emit) fin_d = 1'b1;
    end
  end

  assign ok         = (emit_st == ST_OK);
  assign res_push_o = emit;

  always_comb begin
    res_o.status        = emit_st;
    res_o.msg_kind      = ok ? hw0_d : '0;
    res_o.command_code  = ok ? hw1_d : '0;
    res_o.val_kind      = ok ? hw2_d : '0;
    res_o.payload_value = ok ? emit_val : '0;
    res_o.bytes_used    = ok ? emit_used : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      pos_q      <= '0;
      shift_q    <= '0;
      hw0_q      <= '0;
      hw1_q      <= '0;
      hw2_q      <= '0;
      bad_q      <= 1'b0;
      fin_q      <= 1'b1;
    end else begin
      in_valid_q <= in_valid_d;
      pos_q      <= pos_d;
      shift_q    <= shift_d;
      hw0_q      <= hw0_d;
      hw1_q      <= hw1_d;
      hw2_q      <= hw2_d;
      bad_q      <= bad_d;
      fin_q      <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q  <= data_byte_i;
      first_q <= first_byte_i;
    end
  end

  `UCP_ASSERT_NXT(a_emit_closes, res_push_o, fin_q)
  `UCP_ASSERT_IMP(a_pos_bound, 1'b1, pos_q <= POS_VAL32)
  `UCP_ASSERT_IMP(a_reject_zero, res_push_o && res_o.status != ST_OK,
                  res_o.bytes_used == '0 && res_o.payload_value == '0)

endmodule

/* design/ucp_out_buf.sv */
// Two-entry result register that decouples the parser from output stall.
// Depends on ucp_pkg and the shared assertion macro header.
`include "udp_command_header_parser_core_defines.svh"

module ucp_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ucp_pkg::res_t  res_i,
  output logic           full_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ucp_pkg::res_t  res_o
);
  import ucp_pkg::*;

  res_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign full_o      = (cnt_q == 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o & ~out_stall_i;
  assign res_o       = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) cnt_d = cnt_q + 2'd1;
    else if (!push_i && pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_q <= ~wr_q;
      if (pop)    rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= res_i;
  end

  `UCP_ASSERT_IMP(a_cnt_max, 1'b1, cnt_q <= 2'd2)
  `UCP_ASSERT_IMP(a_no_overflow, push_i, cnt_q != 2'd2)
  `UCP_ASSERT_NXT(a_fill_one, push_i && cnt_q == 2'd0, cnt_q == 2'd1 && wr_q != rd_q)

endmodule

/* design/udp_command_header_parser_core.sv */
// Datagram command header parser: one byte per cycle, at most one result per datagram.
// A result passes from the input register through the 2-entry result buffer before it
// can transfer. Throughput: one byte per cycle, set by the single-pass field logic;
// input stalls only with the buffer full.
// Reset: asynchronous active low; config returns to defaults, parser waits for a first byte.
// Depends on ucp_pkg, ucp_parse and ucp_out_buf.
module udp_command_header_parser_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ucp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ucp_pkg::WORD_W-1:0]       cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [ucp_pkg::BYTE_W-1:0]       data_byte_i,
  input  logic                             first_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [ucp_pkg::STATUS_W-1:0]     status_o,
  output logic [ucp_pkg::HALF_W-1:0]       msg_kind_o,
  output logic [ucp_pkg::HALF_W-1:0]       command_code_o,
  output logic [ucp_pkg::HALF_W-1:0]       val_kind_o,
  output logic signed [ucp_pkg::WORD_W-1:0] payload_value_o,
  output logic [ucp_pkg::USED_W-1:0]       bytes_used_o
);
  import ucp_pkg::*;

  cfg_t cfg_q;
  res_t parse_res, buf_res;
  logic parse_push;
  logic buf_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_word      <= RST_MAGIC;
      cfg_q.len_limit       <= RST_MAXLEN;
      cfg_q.int16_type_code <= RST_INT16;
      cfg_q.int32_type_code <= RST_INT32;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MAGIC:  cfg_q.magic_word      <= cfg_data_i;
        CFG_MAXLEN: cfg_q.len_limit       <= cfg_data_i;
        CFG_INT16:  cfg_q.int16_type_code <= cfg_data_i[HALF_W-1:0];
        CFG_INT32:  cfg_q.int32_type_code <= cfg_data_i[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  ucp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .first_byte_i (first_byte_i),
    .buf_full_i   (buf_full),
    .res_push_o   (parse_push),
    .res_o        (parse_res)
  );

  ucp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (parse_push),
    .res_i       (parse_res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (buf_res)
  );

  assign status_o        = buf_res.status;
  assign msg_kind_o      = buf_res.msg_kind;
  assign command_code_o  = buf_res.command_code;
  assign val_kind_o      = buf_res.val_kind;
  assign payload_value_o = buf_res.payload_value;
  assign bytes_used_o    = buf_res.bytes_used;

endmodule
